// ----- rtl/msm7_pkg.sv -----
`timescale 1ns / 1ps

package msm7_pkg;

    localparam int CHANNELS = 9;
    localparam int WINDOW   = 7;

    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 4;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int RANK_W   = $clog2(WINDOW);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1 + CHAN_W;
    localparam int M_TDATA_W = 16;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef logic [SAMPLE_W-1:0]              sample_t;
    typedef logic [CHAN_W-1:0]                chan_t;
    typedef logic [CH_IDX_W-1:0]              ch_idx_t;
    typedef logic [FILL_W-1:0]                fill_t;
    typedef logic [RANK_W-1:0]                rank_t;
    typedef logic [WINDOW-1:0][SAMPLE_W-1:0]  window_t;

endpackage

// ----- rtl/multichannel_sliding_median7.sv -----
`timescale 1ns / 1ps

// Per-channel sliding median filter for 12-bit samples. A push word (tuser bit 0
// low) enters the channel's window of up to seven samples, dropping the oldest
// once full, and returns the median of the samples held (upper middle for an
// even count); a channel at or beyond the channel count returns the sample
// unchanged. A clear word (tuser bit 0 high) empties every window and returns
// nothing. One word is accepted every cycle while the output is not stalled; a
// result passes through the input register, then the result register. The
// window row is read, updated and ranked combinationally between the two
// registers, so back-to-back words on one channel need no forwarding. Reset
// empties all windows.
module multichannel_sliding_median7
    import msm7_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] action, [4:1] channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [11:0] median
);

    logic    s1_valid_reg, s1_valid_next;
    action_t s1_action_reg, s1_action_next;
    chan_t   s1_chan_reg, s1_chan_next;
    sample_t s1_sample_reg, s1_sample_next;

    window_t              win_reg  [CHANNELS];
    window_t              win_next [CHANNELS];
    fill_t [CHANNELS-1:0] fill_reg, fill_next;

    logic    m_valid_reg, m_valid_next;
    sample_t m_data_reg, m_data_next;

    logic    s_fire, out_free, s1_fire, s1_push_fire, in_range;
    ch_idx_t s1_idx;
    window_t rd_row, new_row;
    fill_t   rd_fill, new_fill;
    sample_t med;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && ((s1_action_reg == ACT_CLEAR) || out_free);
    assign s1_push_fire = s1_fire && (s1_action_reg == ACT_PUSH);
    assign s_tready = !s1_valid_reg || s1_fire;

    assign in_range = ({1'b0, s1_chan_reg} < (CHAN_W + 1)'(CHANNELS));
    assign s1_idx   = ch_idx_t'(s1_chan_reg);
    assign rd_row   = win_reg[s1_idx];
    assign rd_fill  = fill_reg[s1_idx];

    // Append while filling, else drop the oldest and add at the newest end
    always_comb begin
        if (rd_fill == FILL_W'(WINDOW)) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                new_row[i] = rd_row[i+1];
            end
            new_row[WINDOW-1] = s1_sample_reg;
            new_fill = rd_fill;
        end else begin
            for (int i = 0; i < WINDOW; i++) begin
                new_row[i] = (FILL_W'(i) == rd_fill) ? s1_sample_reg : rd_row[i];
            end
            new_fill = rd_fill + FILL_W'(1);
        end
    end

    msm7_median_sel u_median_sel (
        .win    (new_row),
        .count  (new_fill),
        .median (med)
    );

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_action_next = s1_action_reg;
        s1_chan_next   = s1_chan_reg;
        s1_sample_next = s1_sample_reg;
        if (s_fire) begin
            s1_valid_next  = 1'b1;
            s1_action_next = action_t'(s_tuser[0]);
            s1_chan_next   = s_tuser[CHAN_W:1];
            s1_sample_next = s_tdata[SAMPLE_W-1:0];
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end

        win_next  = win_reg;
        fill_next = fill_reg;
        if (s1_fire && (s1_action_reg == ACT_CLEAR)) begin
            fill_next = '0;
        end else if (s1_push_fire && in_range) begin
            win_next[s1_idx]  = new_row;
            fill_next[s1_idx] = new_fill;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s1_push_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = in_range ? med : s1_sample_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fill_reg     <= fill_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_action_reg <= s1_action_next;
        s1_chan_reg   <= s1_chan_next;
        s1_sample_reg <= s1_sample_next;
        m_data_reg    <= m_data_next;
        win_reg       <= win_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

`ifndef NO_ASSERTIONS
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && (s1_action_reg == ACT_CLEAR) |=> (fill_reg == '0))
        else $error("clear left a window non-empty");

    a_push_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_push_fire |=> m_valid_reg)
        else $error("push produced no result");

    a_passthrough: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_push_fire && !in_range |=> (m_data_reg == $past(s1_sample_reg)))
        else $error("out-of-range channel did not pass the sample through");

    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_push_fire && in_range && (rd_fill != FILL_W'(WINDOW))
        |=> (fill_reg[$past(s1_idx)] == fill_t'($past(rd_fill) + FILL_W'(1))))
        else $error("fill count did not advance on push");
`endif

endmodule

// ----- rtl/msm7_median_sel.sv -----
`timescale 1ns / 1ps

// Rank selection: each slot counts the slots that sort ahead of it (ties broken
// by slot index), unused slots sort last; the slot whose rank is count/2 wins.
module msm7_median_sel
    import msm7_pkg::*;
(
    input  window_t win,
    input  fill_t   count,
    output sample_t median
);

    logic [WINDOW-1:0][SAMPLE_W:0] key;
    rank_t [WINDOW-1:0]            rank;
    logic  [WINDOW-1:0]            hit;
    rank_t                         target;

    assign target = rank_t'(count >> 1);

    always_comb begin
        // unused slots carry stale or unwritten data; give them a fixed key
        for (int i = 0; i < WINDOW; i++) begin
            key[i] = (FILL_W'(i) >= count) ? {1'b1, {SAMPLE_W{1'b0}}} : {1'b0, win[i]};
        end
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i) begin
                    if ((key[j] < key[i]) || ((key[j] == key[i]) && (j < i))) begin
                        rank[i] = rank[i] + rank_t'(1);
                    end
                end
            end
            hit[i] = (rank[i] == target);
        end
        median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            median = median | (win[i] & {SAMPLE_W{hit[i]}});
        end
    end

endmodule
